// File: src/khm_pkg.sv
// shared types and constants for the k-way heap merge block
package khm_pkg;

    localparam int VALUE_W         = 32;
    localparam int SRC_RUN_W       = 4;
    localparam int WAYS_W          = 5;
    localparam logic [WAYS_W-1:0] WAYS_RESET = 5'd16;

    // datapath commands, one cycle each
    typedef struct packed {
        logic accept;      // latch the input item
        logic fill_step;   // append the item during fill
        logic build_rd;    // start a build sift at the next internal node
        logic merge_rd;    // fetch the node that replaces the root
        logic load_node;   // capture the moving node
        logic load_merge;  // moving node takes the input value when not exhausted
        logic kids_rd;     // read both children of the current position
        logic cmp_step;    // compare and move one level down
        logic out_load;    // load the output register
    } khm_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic heap_empty;
        logic bstart_zero;
        logic moved;
        logic out_free;
    } khm_status_t;

endpackage

// File: src/khm_ctrl.sv
// control state machine for the k-way heap merge
module khm_ctrl
    import khm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  khm_status_t status,
    output khm_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_MERGE_RD,
        S_LOAD,
        S_KIDS,
        S_CMP,
        S_ROOT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   merging_reg, merging_next;
    logic   building_reg, building_next;

    always_comb
    begin
        state_next    = state_reg;
        merging_next  = merging_reg;
        building_next = building_reg;
        cmd           = '0;
        in_stall      = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!merging_reg)
                    begin
                        cmd.fill_step = 1'b1;
                        if (status.fill_last)
                        begin
                            merging_next  = 1'b1;
                            building_next = 1'b1;
                            state_next    = S_BUILD;
                        end
                    end
                    else if (status.heap_empty)
                    begin
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        state_next = S_MERGE_RD;
                    end
                end
            end
            S_BUILD:
            begin
                if (status.bstart_zero)
                begin
                    building_next = 1'b0;
                    state_next    = S_ROOT;
                end
                else
                begin
                    cmd.build_rd = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            S_MERGE_RD:
            begin
                cmd.merge_rd = 1'b1;
                state_next   = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_node  = 1'b1;
                cmd.load_merge = !building_reg;
                state_next     = S_KIDS;
            end
            S_KIDS:
            begin
                cmd.kids_rd = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp_step = 1'b1;
                if (status.moved)
                    state_next = S_KIDS;
                else if (building_reg)
                    state_next = S_BUILD;
                else
                    state_next = S_ROOT;
            end
            S_ROOT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.heap_empty)
                        merging_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            merging_reg  <= 1'b0;
            building_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            merging_reg  <= merging_next;
            building_reg <= building_next;
        end
    end

endmodule

// File: src/khm_datapath.sv
// heap memory, sift-down compare stage, counters and output register
module khm_datapath
    import khm_pkg::*;
#(
    parameter int MAX_RUNS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  khm_cmd_t                      cmd,
    output khm_status_t                   status,
    input  logic signed [VALUE_W-1:0]     value,
    input  logic                          exhausted,
    input  logic                          ways_we,
    input  logic [WAYS_W-1:0]             ways,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_W-1:0]     value_res,
    output logic [SRC_RUN_W-1:0]          source_run,
    output logic                          done_res
);

    localparam int IW   = $clog2(MAX_RUNS);
    localparam int CW   = $clog2(MAX_RUNS + 1);
    localparam int EW   = (CW > WAYS_W) ? CW : WAYS_W;
    localparam int KW   = IW + 2;
    localparam int PADW = (IW > SRC_RUN_W) ? IW : SRC_RUN_W;

    // heap storage
    logic signed [VALUE_W-1:0] mem_value [MAX_RUNS];
    logic [IW-1:0]             mem_run   [MAX_RUNS];

    logic signed [VALUE_W-1:0] rd0_value_reg, rd1_value_reg;
    logic [IW-1:0]             rd0_run_reg, rd1_run_reg;
    logic [IW-1:0]             rd_addr0, rd_addr1;

    logic                      wr_en;
    logic [IW-1:0]             wr_addr;
    logic signed [VALUE_W-1:0] wr_value;
    logic [IW-1:0]             wr_run;

    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             fill_index_reg, fill_index_next;
    logic [WAYS_W-1:0]         ways_reg, ways_next;
    logic                      out_valid_reg, out_valid_next;

    logic [IW-1:0]             bstart_reg, bstart_next;
    logic [IW-1:0]             pos_reg, pos_next;
    logic signed [VALUE_W-1:0] node_value_reg, node_value_next;
    logic [IW-1:0]             node_run_reg, node_run_next;
    logic signed [VALUE_W-1:0] value_q_reg, value_q_next;
    logic                      ex_q_reg, ex_q_next;
    logic signed [VALUE_W-1:0] value_res_reg, value_res_next;
    logic [SRC_RUN_W-1:0]      source_run_reg, source_run_next;
    logic                      done_res_reg, done_res_next;

    logic [EW-1:0]             rc_ext, eff_runs, fill_next_ext;
    logic [CW-1:0]             base_count, count_fill;
    logic                      append;
    logic [KW-1:0]             left_idx, right_idx;
    logic                      left_ok, right_ok, take_left, take_right;
    logic signed [VALUE_W-1:0] best_value;
    logic [PADW-1:0]           run_pad;
    logic                      heap_empty;

    // effective run count: zero acts as one, large values clip to capacity
    always_comb
    begin
        rc_ext = EW'(ways_reg);
        if (rc_ext == '0)
            eff_runs = EW'(1);
        else if (rc_ext > EW'(MAX_RUNS))
            eff_runs = EW'(MAX_RUNS);
        else
            eff_runs = rc_ext;
        fill_next_ext = EW'(fill_index_reg) + EW'(1);
    end

    assign heap_empty = (count_reg == '0);
    assign base_count = (fill_index_reg == '0) ? '0 : count_reg;
    assign append     = !exhausted && (base_count < CW'(MAX_RUNS));
    assign count_fill = base_count + CW'(append);

    assign left_idx  = KW'({pos_reg, 1'b1});
    assign right_idx = left_idx + KW'(1);
    assign left_ok   = left_idx < KW'(count_reg);
    assign right_ok  = right_idx < KW'(count_reg);

    // left child preferred, a child moves up only when strictly smaller
    always_comb
    begin
        best_value = node_value_reg;
        take_left  = 1'b0;
        take_right = 1'b0;
        if (left_ok && (rd0_value_reg < node_value_reg))
        begin
            best_value = rd0_value_reg;
            take_left  = 1'b1;
        end
        if (right_ok && (rd1_value_reg < best_value))
        begin
            take_left  = 1'b0;
            take_right = 1'b1;
        end
    end

    assign run_pad = PADW'(rd0_run_reg);

    always_comb
    begin
        if (cmd.build_rd)
            rd_addr0 = bstart_reg - IW'(1);
        else if (cmd.merge_rd)
            rd_addr0 = ex_q_reg ? IW'(count_reg - CW'(1)) : '0;
        else if (cmd.kids_rd)
            rd_addr0 = left_idx[IW-1:0];
        else
            rd_addr0 = '0;
        rd_addr1 = right_idx[IW-1:0];
    end

    always_comb
    begin
        count_next      = count_reg;
        fill_index_next = fill_index_reg;
        ways_next       = ways_reg;
        out_valid_next  = out_valid_reg;
        bstart_next     = bstart_reg;
        pos_next        = pos_reg;
        node_value_next = node_value_reg;
        node_run_next   = node_run_reg;
        value_q_next    = value_q_reg;
        ex_q_next       = ex_q_reg;
        value_res_next  = value_res_reg;
        source_run_next = source_run_reg;
        done_res_next   = done_res_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_value        = node_value_reg;
        wr_run          = node_run_reg;

        if (ways_we)
            ways_next = ways;

        if (cmd.accept)
        begin
            value_q_next = value;
            ex_q_next    = exhausted;
        end

        if (cmd.fill_step)
        begin
            wr_en           = append;
            wr_addr         = base_count[IW-1:0];
            wr_value        = value;
            wr_run          = fill_index_reg[IW-1:0];
            count_next      = count_fill;
            fill_index_next = fill_index_reg + CW'(1);
            bstart_next     = IW'(count_fill >> 1);
        end

        if (cmd.build_rd)
        begin
            bstart_next = bstart_reg - IW'(1);
            pos_next    = bstart_reg - IW'(1);
        end

        if (cmd.merge_rd)
        begin
            pos_next = '0;
            if (ex_q_reg)
                count_next = count_reg - CW'(1);
        end

        if (cmd.load_node)
        begin
            node_value_next = (cmd.load_merge && !ex_q_reg) ? value_q_reg : rd0_value_reg;
            node_run_next   = rd0_run_reg;
        end

        if (cmd.cmp_step)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_reg;
            if (take_left)
            begin
                wr_value = rd0_value_reg;
                wr_run   = rd0_run_reg;
                pos_next = left_idx[IW-1:0];
            end
            else if (take_right)
            begin
                wr_value = rd1_value_reg;
                wr_run   = rd1_run_reg;
                pos_next = right_idx[IW-1:0];
            end
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            done_res_next   = heap_empty;
            value_res_next  = heap_empty ? '0 : rd0_value_reg;
            source_run_next = heap_empty ? '0 : run_pad[SRC_RUN_W-1:0];
            if (heap_empty)
                fill_index_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_value[wr_addr] <= wr_value;
            mem_run[wr_addr]   <= wr_run;
        end
        rd0_value_reg <= mem_value[rd_addr0];
        rd0_run_reg   <= mem_run[rd_addr0];
        rd1_value_reg <= mem_value[rd_addr1];
        rd1_run_reg   <= mem_run[rd_addr1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            fill_index_reg <= '0;
            ways_reg       <= WAYS_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            fill_index_reg <= fill_index_next;
            ways_reg       <= ways_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bstart_reg     <= bstart_next;
        pos_reg        <= pos_next;
        node_value_reg <= node_value_next;
        node_run_reg   <= node_run_next;
        value_q_reg    <= value_q_next;
        ex_q_reg       <= ex_q_next;
        value_res_reg  <= value_res_next;
        source_run_reg <= source_run_next;
        done_res_reg   <= done_res_next;
    end

    always_comb
    begin
        status.fill_last   = (fill_next_ext >= eff_runs);
        status.heap_empty  = heap_empty;
        status.bstart_zero = (bstart_reg == '0);
        status.moved       = take_left || take_right;
        status.out_free    = !out_valid_reg || !out_stall;
    end

    assign out_valid  = out_valid_reg;
    assign value_res  = value_res_reg;
    assign source_run = source_run_reg;
    assign done_res   = done_res_reg;

endmodule

// File: src/kway_heap_merge_core.sv
// k-way merge of sorted runs through a binary min-heap, top level
// fill items are accepted while idle; the last one adds the heap build: per internal node a
// load step, then read and compare per level moved; then finish, read, present the root
// merge item: fetch, load, read and compare per level moved, read and present the root;
// one shared compare stage; one item at a time, a result waits in the output reg
// rst_n is asynchronous active low: fill phase, empty heap, ways back to 16
module kway_heap_merge_core
    import khm_pkg::*;
#(
    parameter int MAX_RUNS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      exhausted,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] value_res,
    output logic [SRC_RUN_W-1:0]      source_run,
    output logic                      done_res,
    input  logic                      ways_we,
    input  logic [WAYS_W-1:0]         ways
);

    khm_cmd_t    cmd;
    khm_status_t status;

    khm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    khm_datapath #(
        .MAX_RUNS (MAX_RUNS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .value        (value),
        .exhausted    (exhausted),
        .ways_we      (ways_we),
        .ways         (ways),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value_res    (value_res),
        .source_run   (source_run),
        .done_res     (done_res)
    );

endmodule

// File: src/khm_checker.sv
// port-level checks for the k-way heap merge core, bound to the top level
module khm_checker
    import khm_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic signed [VALUE_W-1:0] value,
    input logic                      exhausted,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [VALUE_W-1:0] value_res,
    input logic [SRC_RUN_W-1:0]      source_run,
    input logic                      done_res
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value_res)
            && $stable(source_run) && $stable(done_res))
        else $error("result changed while stalled");

    // a stalled input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(value) && $stable(exhausted))
        else $error("input item changed while stalled");

    // the done item carries zeros
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> value_res == '0 && source_run == '0)
        else $error("done item carries a value");

    // a new result only comes out of a busy cycle
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work in progress");

    // a result does not appear straight after an accepted item while the core is idle
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid || $past(out_valid) || in_stall)
        else $error("result appeared right after accept");

endmodule

bind kway_heap_merge_core khm_checker u_khm_checker (.*);
